[src/gb7_pkg.sv]
// Shared constants, tap weights and register indexes for the 7x7 Gaussian blur.
package gb7_pkg;

  localparam int WIN        = 7;
  localparam int STORE_ROWS = 6;
  localparam int MAX_HEIGHT = 2048;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [7:0] BORDER_VALUE = 8'd127;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  typedef logic [23:0] q24_t;

  // Q0.24 weights by |dy| and |dx|
  localparam q24_t TAP_Q24 [4][4] = '{
    '{24'd1888100, 24'd1325802, 24'd459029, 24'd78363},
    '{24'd1325802, 24'd930963,  24'd322325, 24'd55025},
    '{24'd459029,  24'd322325,  24'd111598, 24'd19051},
    '{24'd78363,   24'd55025,   24'd19051,  24'd3252}
  };

  // Weight in Q0.frac, rounding half up from Q0.24
  function automatic logic [23:0] tap_weight(input int ady, input int adx, input int frac);
    int          s;
    logic [31:0] w;
    s = 24 - frac;
    w = (32'(TAP_Q24[ady][adx]) + ((32'd1 << s) >> 1)) >> s;
    return w[23:0];
  endfunction

endpackage

[src/gb7_ram.sv]
// Generic single-clock RAM, one write and one registered read port, read-first.
module gb7_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

[src/gaussian_blur_7x7_top.sv]
// Each result passes the stage 1, window, sum and product registers to the output register.
// Throughput: one transaction per cycle unless the output stalls; line store: one RAM word
// per column, read on acceptance, written back from stage 1, forwarded for narrow frames.
// Results for pixel k appear on transaction k + KERNEL_RADIUS*(width+1).
// Reset (synchronous, rst high): frame 640x480, all positions zero, pipeline empty.
// Line store contents are not cleared; unwritten entries only feed border taps.
module gaussian_blur_7x7_top import gb7_pkg::*; #(
  parameter int MAX_WIDTH      = 2048,
  parameter int KERNEL_RADIUS  = 3,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [7:0] pixel_value
  input  logic [0:0]            s_tuser,   // [0] drain
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [7:0]            m_tdata,   // [7:0] blurred_pixel
  output logic                  m_tlast
);

  localparam int CB   = $clog2(MAX_WIDTH);
  localparam int WB   = CB + 1;
  localparam int K    = KERNEL_RADIUS;
  localparam int BASE = WIN - 1 - 2 * K;
  localparam int F    = COEF_FRAC_BITS;
  localparam int DB   = $clog2(K * (MAX_WIDTH + 1) + 1);
  localparam int GW   = 11;
  localparam int PW   = GW + F;
  localparam int AW   = PW + 4;
  localparam int RW   = 8 * STORE_ROWS;

  logic [11:0]    frame_width, frame_height;
  logic [WB-1:0]  eff_w;
  logic [11:0]    eff_h;
  logic [DB-1:0]  delay;

  logic [CB-1:0]  in_column, out_column;
  logic [11:0]    in_row, out_row;
  logic [2:0]     in_slot;
  logic [DB-1:0]  seen;

  logic           adv, accept, in_frame, take, emit, last;
  logic [7:0]     pix;
  logic [WIN-1:0] rmask, cmask;

  always_comb begin
    if (frame_width == 12'd0) eff_w = WB'(1);
    else if (int'(frame_width) > MAX_WIDTH) eff_w = WB'(MAX_WIDTH);
    else eff_w = WB'(frame_width);
    if (frame_height == 12'd0) eff_h = 12'd1;
    else if (int'(frame_height) > MAX_HEIGHT) eff_h = 12'(MAX_HEIGHT);
    else eff_h = frame_height;
  end

  assign delay    = DB'(K * (int'(eff_w) + 1));
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign accept   = s_tvalid && s_tready;
  assign in_frame = in_row < eff_h;
  assign take     = accept && !(in_frame && s_tuser[0]);
  assign pix      = in_frame ? s_tdata : BORDER_VALUE;
  assign emit     = seen >= delay;
  assign last     = emit && (out_row >= eff_h - 12'd1) && ({1'b0, out_column} >= eff_w - WB'(1));

  // taps of the output window that lie inside the frame
  always_comb begin
    for (int a = 0; a < WIN; a++) begin
      rmask[a] = (int'(out_row) + a - K >= 0) && (int'(out_row) + a - K < int'(eff_h));
      cmask[a] = (int'(out_column) + a - K >= 0) && (int'(out_column) + a - K < int'(eff_w));
    end
  end

  // position tracking and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= 12'd640;
      frame_height <= 12'd480;
      in_column    <= '0;
      in_row       <= '0;
      in_slot      <= '0;
      out_column   <= '0;
      out_row      <= '0;
      seen         <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT) begin
        if (cfg_index == REG_FRAME_WIDTH) frame_width <= cfg_data;
        else frame_height <= cfg_data;
        in_column  <= '0;
        in_row     <= '0;
        in_slot    <= '0;
        out_column <= '0;
        out_row    <= '0;
        seen       <= '0;
      end
    end else if (take) begin
      if (last) begin
        in_column  <= '0;
        in_row     <= '0;
        in_slot    <= '0;
        out_column <= '0;
        out_row    <= '0;
        seen       <= '0;
      end else begin
        if ({1'b0, in_column} + WB'(1) >= eff_w) begin
          in_column <= '0;
          in_row    <= in_row + 12'd1;
          in_slot   <= (in_slot == 3'(STORE_ROWS - 1)) ? 3'd0 : in_slot + 3'd1;
        end else begin
          in_column <= in_column + CB'(1);
        end
        if (!emit) begin
          seen <= seen + DB'(1);
        end else if ({1'b0, out_column} + WB'(1) >= eff_w) begin
          out_column <= '0;
          out_row    <= out_row + 12'd1;
        end else begin
          out_column <= out_column + CB'(1);
        end
      end
    end
  end

  // stage 1: line store read in flight
  logic           v1, r1, l1;
  logic [WIN-1:0] rm1, cm1;
  logic [7:0]     pix1;
  logic [2:0]     slot1;
  logic [CB-1:0]  col1;
  logic [RW-1:0]  ram_rdata, rd_word, wr_word, fwd_word;
  logic           fwd;

  gb7_ram #(.WIDTH(RW), .DEPTH(MAX_WIDTH)) u_rows (
    .clk   (clk),
    .re    (take),
    .raddr (in_column),
    .rdata (ram_rdata),
    .we    (adv && v1),
    .waddr (col1),
    .wdata (wr_word)
  );

  assign rd_word = fwd ? fwd_word : ram_rdata;

  always_comb begin
    wr_word = rd_word;
    wr_word[8*slot1 +: 8] = pix1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      r1  <= 1'b0;
      fwd <= 1'b0;
    end else if (adv) begin
      v1  <= take;
      r1  <= take && emit;
      fwd <= take && v1 && (in_column == col1);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l1       <= last;
      rm1      <= rmask;
      cm1      <= cmask;
      pix1     <= pix;
      slot1    <= in_slot;
      col1     <= in_column;
      fwd_word <= wr_word;
    end
  end

  // stage 2: window shift
  logic [7:0]     win [WIN][WIN];
  logic           r2, l2;
  logic [WIN-1:0] rm2, cm2;

  always_ff @(posedge clk) begin
    if (rst) begin
      r2 <= 1'b0;
      for (int y = 0; y < WIN; y++) begin
        for (int x = 0; x < WIN; x++) win[y][x] <= 8'd0;
      end
    end else if (adv) begin
      r2 <= r1;
      if (v1) begin
        for (int y = 0; y < WIN; y++) begin
          for (int x = 0; x < WIN - 1; x++) win[y][x] <= win[y][x + 1];
          if (y < STORE_ROWS) begin
            // row slot of this window row, wrapped once past the last slot
            win[y][WIN-1] <= rd_word[8 * ((int'(slot1) + y >= STORE_ROWS) ?
                                          int'(slot1) + y - STORE_ROWS :
                                          int'(slot1) + y) +: 8];
          end else begin
            win[y][WIN-1] <= pix1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l2  <= l1;
      rm2 <= rm1;
      cm2 <= cm1;
    end
  end

  // stage 3: sums of taps sharing a weight
  logic [GW-1:0] gsum [16];
  logic [GW-1:0] sum3 [16];
  logic          r3, l3;

  always_comb begin
    for (int g = 0; g < 16; g++) gsum[g] = '0;
    for (int a = 0; a <= 2 * K; a++) begin
      for (int b = 0; b <= 2 * K; b++) begin
        gsum[(a > K ? a - K : K - a) * 4 + (b > K ? b - K : K - b)] +=
          GW'((rm2[a] && cm2[b]) ? win[BASE + a][BASE + b] : BORDER_VALUE);
      end
    end
  end

  // stage 4: constant weight products
  logic [PW-1:0] prod4 [16];
  logic          r4, l4;

  // stage 5: total, truncate, saturate
  logic [AW-1:0] total;
  logic [AW-F-1:0] whole;

  always_comb begin
    total = '0;
    for (int g = 0; g < 16; g++) total += AW'(prod4[g]);
    whole = total[AW-1:F];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r3       <= 1'b0;
      r4       <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      r3       <= r2;
      r4       <= r3;
      m_tvalid <= r4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l3 <= l2;
      l4 <= l3;
      for (int g = 0; g < 16; g++) begin
        sum3[g]  <= gsum[g];
        prod4[g] <= PW'(sum3[g]) * PW'(tap_weight(g / 4, g % 4, F));
      end
      m_tlast <= l4;
      m_tdata <= (whole > (AW-F)'(255)) ? 8'd255 : whole[7:0];
    end
  end

endmodule

[src/gb7_checker.sv]
// Port-level checks for the Gaussian blur top level, bound to it.
module gb7_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output transaction changed");

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output register");

  a_stall_follows: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while output stalled");

endmodule

bind gaussian_blur_7x7_top gb7_checker u_gb7_checker (.*);
